FILE: rtl/asdf_pkg.sv
`default_nettype none

package asdf_pkg;

    localparam int DIV_STEPS = 48;
    localparam int DIV_WIDTH = 64;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FLOOR_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_SPEED = 1'b1;

    localparam logic [31:0] MAX_SPEED_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] rem;
        logic [DIV_WIDTH-1:0] dvd;
        logic [DIV_WIDTH-1:0] dvs;
        logic [DIV_STEPS-1:0] quo;
    } lane_t;

    typedef struct packed {
        lane_t       qd;
        lane_t       td;
        logic [47:0] energy;
        logic [31:0] density;
        logic [46:0] half_v2;
        logic        applied;
        logic        zero;
        logic        sat;
    } item_t;

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    function automatic lane_t div_step(lane_t l);
        logic [DIV_WIDTH:0] trial;
        lane_t              r;
        r = l;
        trial = {l.rem, l.dvd[DIV_WIDTH-1]};
        if (trial >= {1'b0, l.dvs})
        begin
            r.rem = DIV_WIDTH'(trial - {1'b0, l.dvs});
            r.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DIV_WIDTH-1:0];
            r.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
        end
        r.dvd = {l.dvd[DIV_WIDTH-2:0], 1'b0};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/alfven_speed_density_floor_core.sv
`default_nettype none
// Pipeline: three set-up stages, one cell per quotient bit of the two 48-step dividers,
// and one output stage between an accepted input transaction and its result.
// Throughput: one transaction per cycle; the whole chain holds while a result is refused.
// Reset clears all valid flags and sets floor_enable to 1 and max_alfven_speed to 1.0.

module alfven_speed_density_floor_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_write_en,
    input  wire logic [asdf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [31:0]                             cfg_data,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [31:0]                             density,
    input  wire logic signed [23:0]                      field_x,
    input  wire logic signed [23:0]                      field_y,
    input  wire logic signed [23:0]                      field_z,
    input  wire logic signed [47:0]                      total_energy,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [31:0]                                  density_out,
    output logic signed [47:0]                           total_energy_out,
    output logic                                         floor_applied,
    output logic                                         zero_density
);

    localparam int N = asdf_pkg::DIV_STEPS;

    logic        floor_enable_reg;
    logic [31:0] max_speed_reg;
    logic        advance;

    logic        p1_valid_reg;
    logic [47:0] p1_sqx_reg;
    logic [47:0] p1_sqy_reg;
    logic [47:0] p1_sqz_reg;
    logic [63:0] p1_v2_reg;
    logic [31:0] p1_rho_reg;
    logic [47:0] p1_e_reg;
    logic        p1_en_reg;

    logic        p2_valid_reg;
    logic [47:0] p2_b2_reg;
    logic [63:0] p2_pplo_reg;
    logic [63:0] p2_pphi_reg;
    logic [63:0] p2_v2_reg;
    logic [31:0] p2_rho_reg;
    logic [47:0] p2_e_reg;
    logic        p2_en_reg;

    logic        p3_valid_reg;
    logic [47:0] p3_b2_reg;
    logic [95:0] p3_rhs_reg;
    logic [63:0] p3_v2_reg;
    logic [31:0] p3_rho_reg;
    logic [47:0] p3_e_reg;
    logic        p3_en_reg;

    logic signed [47:0] sqx;
    logic signed [47:0] sqy;
    logic signed [47:0] sqz;
    logic [63:0]        lhs;
    asdf_pkg::item_t    init_item;

    logic            cell_valid [0:N];
    asdf_pkg::item_t cell_item [0:N];

    asdf_pkg::item_t    last;
    logic [31:0]        rho_next;
    logic signed [49:0] sum;
    logic [47:0]        e_next;

    logic        out_valid_reg;
    logic [31:0] density_out_reg;
    logic [47:0] energy_out_reg;
    logic        applied_reg;
    logic        zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_enable_reg <= 1'b1;
            max_speed_reg <= asdf_pkg::MAX_SPEED_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                asdf_pkg::REG_FLOOR_ENABLE: floor_enable_reg <= cfg_data[0];
                asdf_pkg::REG_MAX_SPEED:    max_speed_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;

    assign sqx = 48'(field_x) * 48'(field_x);
    assign sqy = 48'(field_y) * 48'(field_y);
    assign sqz = 48'(field_z) * 48'(field_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_sqx_reg <= sqx;
            p1_sqy_reg <= sqy;
            p1_sqz_reg <= sqz;
            p1_v2_reg <= 64'(max_speed_reg) * 64'(max_speed_reg);
            p1_rho_reg <= density;
            p1_e_reg <= total_energy;
            p1_en_reg <= floor_enable_reg;

            p2_b2_reg <= p1_sqx_reg + p1_sqy_reg + p1_sqz_reg;
            p2_pplo_reg <= 64'(p1_v2_reg[31:0]) * 64'(p1_rho_reg);
            p2_pphi_reg <= 64'(p1_v2_reg[63:32]) * 64'(p1_rho_reg);
            p2_v2_reg <= p1_v2_reg;
            p2_rho_reg <= p1_rho_reg;
            p2_e_reg <= p1_e_reg;
            p2_en_reg <= p1_en_reg;

            p3_b2_reg <= p2_b2_reg;
            p3_rhs_reg <= 96'(p2_pplo_reg) + {p2_pphi_reg, 32'd0};
            p3_v2_reg <= p2_v2_reg;
            p3_rho_reg <= p2_rho_reg;
            p3_e_reg <= p2_e_reg;
            p3_en_reg <= p2_en_reg;
        end
    end

    assign lhs = {p3_b2_reg, 16'd0};

    always_comb
    begin
        init_item.zero = (p3_rho_reg == 32'd0);
        init_item.applied = !init_item.zero && p3_en_reg && (96'(lhs) > p3_rhs_reg);
        init_item.sat = (p3_v2_reg == 64'd0) || (64'(lhs[63:48]) >= p3_v2_reg);
        init_item.energy = p3_e_reg;
        init_item.density = p3_rho_reg;
        init_item.half_v2 = p3_v2_reg[63:17];
        init_item.qd.rem = 64'(lhs[63:48]);
        init_item.qd.dvd = {lhs[47:0], 16'd0};
        init_item.qd.dvs = p3_v2_reg;
        init_item.qd.quo = '0;
        init_item.td.rem = 64'd0;
        init_item.td.dvd = {p3_b2_reg, 16'd0};
        init_item.td.dvs = {31'd0, p3_rho_reg, 1'b0};
        init_item.td.quo = '0;
    end

    assign cell_valid[0] = p3_valid_reg;
    assign cell_item[0] = init_item;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        asdf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (cell_valid[k]),
            .prev_item  (cell_item[k]),
            .valid      (cell_valid[k+1]),
            .item       (cell_item[k+1])
        );
    end

    assign last = cell_item[N];

    always_comb
    begin
        if (last.sat || (last.qd.quo[N-1:32] != '0))
        begin
            rho_next = 32'hFFFF_FFFF;
        end
        else
        begin
            rho_next = last.qd.quo[31:0];
        end
        sum = 50'(signed'(last.energy)) - signed'(50'(last.td.quo))
            + signed'(50'(last.half_v2));
        if (sum > 50'sh0_7FFF_FFFF_FFFF)
        begin
            e_next = 48'h7FFF_FFFF_FFFF;
        end
        else if (sum < -50'sh0_8000_0000_0000)
        begin
            e_next = 48'h8000_0000_0000;
        end
        else
        begin
            e_next = sum[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cell_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            density_out_reg <= last.applied ? rho_next : last.density;
            energy_out_reg <= last.applied ? e_next : last.energy;
            applied_reg <= last.applied;
            zero_reg <= last.zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign density_out = density_out_reg;
    assign total_energy_out = energy_out_reg;
    assign floor_applied = applied_reg;
    assign zero_density = zero_reg;

endmodule

`default_nettype wire

FILE: rtl/asdf_cell.sv
`default_nettype none

module asdf_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            prev_valid,
    input  wire asdf_pkg::item_t prev_item,
    output logic                 valid,
    output asdf_pkg::item_t      item
);

    logic            valid_reg;
    asdf_pkg::item_t item_reg;
    asdf_pkg::item_t item_next;

    always_comb
    begin
        item_next = prev_item;
        item_next.qd = asdf_pkg::div_step(prev_item.qd);
        item_next.td = asdf_pkg::div_step(prev_item.td);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire
